@@ hw/rtl/owrm_pkg.sv @@
// ----------------------------------------------------------------------------
// owrm_pkg
// Shared widths, defaults and the entry type of the overwriting ring with
// window mean.
// ----------------------------------------------------------------------------
package owrm_pkg;

   localparam int TAG_W         = 16;
   localparam int YEAR_W        = 12;
   localparam int DEPTH_DEFAULT = 8;

   // Both streams carry a 16-bit tag and a 12-bit year, padded to 32 bits.
   localparam int DATA_W = 32;

   // Number of quotient bits produced by the mean divider.
   localparam int QUO_W = YEAR_W;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [YEAR_W-1:0] year;
   } entry_type;

endpackage

@@ hw/rtl/overwriting_ring_with_window_mean.sv @@
// ----------------------------------------------------------------------------
// overwriting_ring_with_window_mean
// Ring of up to DEPTH tagged years that reports evictions and the rounded
// mean year of the held entries.
// ----------------------------------------------------------------------------
// Each accepted word is appended to the ring; when the ring already holds
// DEPTH entries the oldest one is dropped first and its tag comes back with
// the evicted flag set in rsp_tuser (tag reads as zero otherwise). The mean
// is round-half-up of the held years, taken from a running total. The total,
// numerator and divider arithmetic goes through one shared add/subtract unit
// under a small sequencer, and the division is a restoring divider producing
// one quotient bit per cycle. After a word is accepted the sequencer runs a
// total subtract step (only on an eviction), one total update step, one
// numerator set-up step, the 12 divider steps and one output step, which
// waits for the output register to be free. req_tready is low during that
// time, so no new word is taken until the result is loaded. The result sits in
// an output register, so the block may accept the next word while it waits
// to be taken.
// ----------------------------------------------------------------------------
module overwriting_ring_with_window_mean
   import owrm_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,  // [15:0] item_tag, [27:16] year_value
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,  // [15:0] evicted_tag, [27:16] mean_year
   output logic [0:0]        rsp_tuser   // [0] evicted
);

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int TOT_W  = YEAR_W + CNT_W;
   localparam int ALU_W  = CNT_W + QUO_W + 1;
   localparam int STEP_W = $clog2(QUO_W);
   localparam int PAD_W  = DATA_W - TAG_W - YEAR_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SUB  = 3'd1;
   localparam logic [2:0] ST_ADD  = 3'd2;
   localparam logic [2:0] ST_NUM  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [YEAR_W-1:0] year_ff, year_in;
   logic              full_ff, full_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [ALU_W-1:0]  rem_ff, rem_in;
   logic [ALU_W-1:0]  dsr_ff, dsr_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [TAG_W-1:0]  ev_tag_ff, ev_tag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff, rsp_user_in;

   logic [ALU_W-1:0]  alu_a;
   logic [ALU_W-1:0]  alu_b;
   logic              alu_sub;
   logic [ALU_W:0]    alu_wide;
   logic              alu_borrow;

   logic              ring_wr_en;
   entry_type         ring_wr_entry;
   entry_type         ring_rd_entry;
   logic              req_accept;

   assign req_accept = req_tvalid && (state_ff == ST_IDLE);

   owrm_ring #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_ring (
      .clock    (clock),
      .wr_en    (ring_wr_en),
      .wr_idx   (tail_ff),
      .wr_entry (ring_wr_entry),
      .rd_idx   (head_ff),
      .rd_entry (ring_rd_entry)
   );

   assign ring_wr_en          = (state_ff == ST_ADD);
   assign ring_wr_entry.tag   = tag_ff;
   assign ring_wr_entry.year  = year_ff;

   // Shared add/subtract unit; the top bit of the wide result is the borrow.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         ST_SUB: begin
            alu_a   = ALU_W'(total_ff);
            alu_b   = ALU_W'(ring_rd_entry.year);
            alu_sub = 1'b1;
         end
         ST_ADD: begin
            alu_a = ALU_W'(total_ff);
            alu_b = ALU_W'(year_ff);
         end
         ST_NUM: begin
            alu_a = ALU_W'({total_ff, 1'b0});
            alu_b = ALU_W'(count_ff);
         end
         ST_DIV: begin
            alu_a   = rem_ff;
            alu_b   = dsr_ff;
            alu_sub = 1'b1;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   assign alu_wide   = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                               : ({1'b0, alu_a} + {1'b0, alu_b});
   assign alu_borrow = alu_wide[ALU_W];

   always_comb begin
      state_in     = state_ff;
      tag_in       = tag_ff;
      year_in      = year_ff;
      full_in      = full_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      ev_tag_in    = ev_tag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               tag_in    = req_tdata[TAG_W-1:0];
               year_in   = req_tdata[TAG_W +: YEAR_W];
               full_in   = (count_ff == CNT_W'(DEPTH));
               ev_tag_in = '0;
               state_in  = (count_ff == CNT_W'(DEPTH)) ? ST_SUB : ST_ADD;
            end
         end
         ST_SUB: begin
            // The head entry was read on the accepting edge and is still valid.
            total_in  = alu_wide[TOT_W-1:0];
            ev_tag_in = ring_rd_entry.tag;
            head_in   = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
            state_in  = ST_ADD;
         end
         ST_ADD: begin
            total_in = alu_wide[TOT_W-1:0];
            count_in = full_ff ? count_ff : count_ff + 1'b1;
            tail_in  = (tail_ff == IDX_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            // Numerator is 2*total+count; the divisor starts at 2*count
            // aligned with the top quotient bit.
            rem_in   = alu_wide[ALU_W-1:0];
            dsr_in   = ALU_W'(count_ff) << QUO_W;
            quo_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!alu_borrow) begin
               rem_in = alu_wide[ALU_W-1:0];
            end
            quo_in  = {quo_ff[QUO_W-2:0], !alu_borrow};
            dsr_in  = dsr_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{PAD_W{1'b0}}, quo_ff, ev_tag_ff};
               rsp_user_in  = full_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff      <= tag_in;
      year_ff     <= year_in;
      full_ff     <= full_in;
      rem_ff      <= rem_in;
      dsr_ff      <= dsr_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      ev_tag_ff   <= ev_tag_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ hw/rtl/owrm_ring.sv @@
// ----------------------------------------------------------------------------
// owrm_ring
// Ring storage for tag and year entries: one write port and one read port
// with registered read data.
// ----------------------------------------------------------------------------
module owrm_ring
   import owrm_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  entry_type        wr_entry,
   input  logic [IDX_W-1:0] rd_idx,
   output entry_type        rd_entry
);

   entry_type mem [DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_idx];
   end

   assign rd_entry = rd_entry_ff;

endmodule

@@ hw/rtl/owrm_checker.sv @@
// ----------------------------------------------------------------------------
// owrm_checker
// Port-level checks of the overwriting ring with window mean, bound to the
// top level.
// ----------------------------------------------------------------------------
module owrm_checker
   import owrm_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic [0:0]        rsp_tuser
);

   // No result word may appear right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word shown after reset");

   // A stalled result word stays and holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // The block is busy for the cycle after it takes a word.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again right after a word");

   // Without an eviction the reported tag is zero, and padding is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[DATA_W-1:TAG_W+YEAR_W] == '0
         && (rsp_tuser[0] || rsp_tdata[TAG_W-1:0] == '0))
      else $error("result word carries a stray tag or padding");

endmodule

bind overwriting_ring_with_window_mean owrm_checker u_owrm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
